FILE: hw/rtl/rad_pkg.sv
// shared types, constants and segment decoding for the range average display driver
`default_nettype none

package rad_pkg;

	// fixed field and register widths, digit count and default window depth
	localparam int unsigned ECHO_W      = 16;
	localparam int unsigned REG_W       = 16;
	localparam int unsigned SHOW_W      = 14;
	localparam int unsigned DIGIT_COUNT = 4;
	localparam int unsigned POS_W       = 2;
	localparam int unsigned WINDOW_DEF  = 10;

	// configuration reset values
	localparam logic [REG_W-1:0] PERIOD_RST = 16'd25;
	localparam logic [REG_W-1:0] SCALE_RST  = 16'd5571;
	localparam logic [REG_W-1:0] MIN_RST    = 16'd20;
	localparam logic [REG_W-1:0] MAX_RST    = 16'd4000;

	// fixed point constants and display limits
	localparam logic [15:0] INCH_RECIP  = 16'd25802;   // 1/2.54 in Q0.16
	localparam logic [15:0] DIV10_RECIP = 16'd52429;   // 1/10 in Q0.19
	localparam int unsigned DIV10_SHIFT = 19;
	localparam logic [SHOW_W-1:0] SHOW_MAX    = 14'd9999;
	localparam logic [SHOW_W-1:0] BLANK_BELOW2 = 14'd100;
	localparam logic [SHOW_W-1:0] BLANK_BELOW3 = 14'd1000;
	localparam logic [3:0] ERR_CODE = 4'd10;

	// display positions with special handling
	localparam logic [POS_W-1:0] POS_POINT = 2'd1;
	localparam logic [POS_W-1:0] POS_TOP2  = 2'd2;
	localparam logic [POS_W-1:0] POS_TOP3  = 2'd3;

	typedef struct packed {
		logic [ECHO_W-1:0] echo_ticks;
		logic              inch_mode;
	} in_t;

	typedef struct packed {
		logic [3:0]       digit_enable;
		logic [7:0]       segments;
		logic [POS_W-1:0] scan_index;
	} out_t;

	typedef enum logic [1:0] {
		REG_UPDATE_PERIOD = 2'd0,
		REG_ECHO_SCALE    = 2'd1,
		REG_MIN_TENTHS    = 2'd2,
		REG_MAX_TENTHS    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_CONV,
		ST_SAT,
		ST_DIG,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_ECHO,
		MUL_INCH,
		MUL_TEN
	} mul_sel_t;

	typedef struct packed {
		logic     accept;
		mul_sel_t mul_sel;
		logic     mul_load;
		logic     win_rd;
		logic     push;
		logic     div_load;
		logic     oor_load;
		logic     sat_load;
		logic     dig_step;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fire;
		logic dig_last;
	} dp_sts_t;

	// seven segment pattern, segments a-g on bits 0-6
	function automatic logic [6:0] seg_code(input logic [3:0] d);
		logic [6:0] s;
		unique case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h67;
			4'd10:   s = 7'h79;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/range_average_seven_segment_driver_unit.sv
// Multiplexed four digit display driver fed by averaged range samples. Each accepted word is
// one scan tick and yields exactly one display word for the next position in turn (0 to 3).
// A tick that does not refresh goes from accept straight to output load. Every update_period+1
// ticks a refresh runs: scale the echo, push it into the sliding window, average, range check,
// optional inch conversion and decimal split; that tick runs through accept, echo scaling,
// window push, divide by WINDOW through a reciprocal multiply, range check with inch
// conversion, saturation, four digit steps and output load. A stalled display word holds the
// next tick's output load back until it is taken. No clearing pass is needed after reset. Configuration
// registers: 0 update period, 1 echo scale, 2 minimum tenths, 3 maximum tenths.
`default_nettype none

module range_average_seven_segment_driver_unit import rad_pkg::*; #(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sample_valid,
	output logic                  sample_stall,
	input  wire in_t              sample_word,
	output logic                  disp_valid,
	input  wire logic             disp_stall,
	output out_t                  disp_word,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [REG_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer
	rad_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.disp_valid   (disp_valid),
		.disp_stall   (disp_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// arithmetic and storage
	rad_datapath #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_word (sample_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.disp_word   (disp_word)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/rad_datapath.sv
// datapath: config registers, sample window, shared multiplier, divider, digit split, output word
`default_nettype none

module rad_datapath import rad_pkg::*; #(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire in_t                 sample_word,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [REG_W-1:0]    cfg_data,
	input  wire ctrl_cmd_t           cmd,
	output dp_sts_t                  sts,
	output out_t                     disp_word
);

	localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SUM_W  = ECHO_W + PTR_W;
	localparam int unsigned DIG_W  = $clog2(DIGIT_COUNT);
	// reciprocal of the window depth, exact for every sum of SUM_W bits
	localparam int unsigned DIV_SH = SUM_W + PTR_W;
	localparam int unsigned M_W    = SUM_W + 2;
	localparam int unsigned QP_W   = SUM_W + M_W;
	localparam logic [M_W-1:0] DIV_M =
		M_W'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic [REG_W-1:0]  period_q, scale_q, min_q, max_q;
	logic [ECHO_W-1:0] echo_q;
	logic              inch_q;
	logic [REG_W-1:0]  tick_q;
	logic [15:0]       mul_a, mul_b;
	logic [31:0]       mul_p;
	logic [31:0]       prod_q;
	logic [ECHO_W-1:0] win_mem [WINDOW];
	logic [ECHO_W-1:0] rd_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              full_q;
	logic [SUM_W-1:0]  sum_q;
	logic [ECHO_W-1:0] oldest;
	logic [QP_W-1:0]   quot_p;
	logic [15:0]       avg_q;
	logic [15:0]       avg;
	logic              oor_q;
	logic [SHOW_W-1:0] shown_q;
	logic [SHOW_W-1:0] val_q;
	logic [15:0]       conv_v;
	logic [SHOW_W-1:0] sat_v;
	logic [3:0]        dig_q [DIGIT_COUNT];
	logic [DIG_W-1:0]  dig_cnt_q;
	logic [12:0]       quot10;
	logic [SHOW_W-1:0] quot10_x10;
	logic [SHOW_W-1:0] dig_rem;
	logic [POS_W-1:0]  scan_q;
	logic              lit;
	logic [3:0]        cur_d;
	out_t              disp_d;
	out_t              disp_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			scale_q  <= SCALE_RST;
			min_q    <= MIN_RST;
			max_q    <= MAX_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_UPDATE_PERIOD: period_q <= cfg_data;
				REG_ECHO_SCALE:    scale_q  <= cfg_data;
				REG_MIN_TENTHS:    min_q    <= cfg_data;
				REG_MAX_TENTHS:    max_q    <= cfg_data;
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			echo_q <= sample_word.echo_ticks;
			inch_q <= sample_word.inch_mode;
		end
	end

	// refresh divider
	assign sts.fire = (tick_q == period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (cmd.accept) begin
			tick_q <= sts.fire ? '0 : tick_q + REG_W'(1);
		end
	end

	// shared multiplier
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_ECHO: begin
				mul_a = echo_q;
				mul_b = scale_q;
			end
			MUL_INCH: begin
				mul_a = avg;
				mul_b = INCH_RECIP;
			end
			MUL_TEN: begin
				mul_a = 16'(val_q);
				mul_b = DIV10_RECIP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			prod_q <= mul_p;
		end
	end

	// sample window memory
	always_ff @(posedge clk) begin
		if (cmd.win_rd) begin
			rd_q <= win_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_mem[ptr_q] <= prod_q[31:16];
		end
	end

	// entries not yet written read as zero until the first wrap
	assign oldest = full_q ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (cmd.push) begin
			sum_q <= sum_q - SUM_W'(oldest) + SUM_W'(prod_q[31:16]);
			if (ptr_q == PTR_W'(WINDOW - 1)) begin
				ptr_q  <= '0;
				full_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
		end
	end

	// divide by the window depth through a reciprocal multiply
	assign quot_p = QP_W'(sum_q) * QP_W'(DIV_M);
	assign avg    = avg_q;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			avg_q <= quot_p[DIV_SH +: 16];
		end
	end

	// range check, unit conversion and saturation
	assign conv_v = inch_q ? prod_q[31:16] : avg;
	assign sat_v  = (conv_v > 16'(SHOW_MAX)) ? SHOW_MAX : conv_v[SHOW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_q   <= 1'b1;
			shown_q <= '0;
		end else begin
			if (cmd.oor_load) begin
				oor_q <= (avg < min_q) || (avg > max_q);
			end
			if (cmd.sat_load) begin
				shown_q <= sat_v;
			end
		end
	end

	// decimal split, least significant digit first
	assign quot10     = mul_p[DIV10_SHIFT +: 13];
	assign quot10_x10 = SHOW_W'({quot10, 3'b000}) + SHOW_W'({quot10, 1'b0});
	assign dig_rem    = val_q - quot10_x10;
	assign sts.dig_last = (dig_cnt_q == DIG_W'(DIGIT_COUNT - 1));

	always_ff @(posedge clk) begin
		if (cmd.sat_load) begin
			val_q <= sat_v;
		end else if (cmd.dig_step) begin
			val_q <= SHOW_W'(quot10);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_cnt_q <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				dig_q[i] <= '0;
			end
		end else if (cmd.sat_load) begin
			dig_cnt_q <= '0;
		end else if (cmd.dig_step) begin
			dig_q[dig_cnt_q] <= dig_rem[3:0];
			dig_cnt_q        <= dig_cnt_q + DIG_W'(1);
		end
	end

	// scan position and output word
	always_comb begin
		if (oor_q) begin
			lit = (scan_q == POS_TOP3);
		end else begin
			lit = !((shown_q < BLANK_BELOW2) && (scan_q >= POS_TOP2)) &&
			      !((shown_q < BLANK_BELOW3) && (scan_q == POS_TOP3));
		end
		cur_d = oor_q ? ERR_CODE : dig_q[scan_q];
		disp_d.scan_index   = scan_q;
		disp_d.digit_enable = lit ? (4'b0001 << scan_q) : 4'b0000;
		disp_d.segments     = lit ?
			{(scan_q == POS_POINT) && (cur_d != ERR_CODE), seg_code(cur_d)} : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.out_load) begin
			scan_q <= scan_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			disp_q <= disp_d;
		end
	end

	assign disp_word = disp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rad_controller.sv
// controller: sequences each tick, through the refresh steps when one is due, and owns both handshakes
`default_nettype none

module rad_controller import rad_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      sample_valid,
	output logic           sample_stall,
	output logic           disp_valid,
	input  wire logic      disp_stall,
	input  wire dp_sts_t   sts,
	output ctrl_cmd_t      cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || !disp_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.fire ? ST_MUL : ST_OUT;
				end
			end
			ST_MUL: begin
				cmd.mul_sel  = MUL_ECHO;
				cmd.mul_load = 1'b1;
				cmd.win_rd   = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				cmd.push = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_load = 1'b1;
				state_d      = ST_CONV;
			end
			ST_CONV: begin
				cmd.mul_sel  = MUL_INCH;
				cmd.mul_load = 1'b1;
				cmd.oor_load = 1'b1;
				state_d      = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat_load = 1'b1;
				state_d      = ST_DIG;
			end
			ST_DIG: begin
				cmd.mul_sel  = MUL_TEN;
				cmd.dig_step = 1'b1;
				if (sts.dig_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!disp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign disp_valid   = out_valid_q;

	// a loaded word is presented on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> disp_valid)
		else $error("output word not presented after load");

	// a tick without refresh goes straight to the output step
	a_plain_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && sample_valid && !sts.fire) |=> (state_q == ST_OUT))
		else $error("plain tick did not reach output step");

	// the divide step hands over to unit conversion
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (state_q == ST_CONV))
		else $error("divider did not finish into conversion");

	// a held word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(disp_valid && disp_stall) |-> !cmd.out_load)
		else $error("stalled output word overwritten");

endmodule

`default_nettype wire
